// ===== hw/rtl/dtrd_pkg.sv =====
// Shared types and constants for the disk image track record decoder.
// No dependencies; imported by every module of the block except dtrd_map_ram.
package dtrd_pkg;

    // Result kinds
    localparam logic [2:0] KIND_DESC = 3'd0;
    localparam logic [2:0] KIND_DATA = 3'd1;
    localparam logic [2:0] KIND_FILL = 3'd2;
    localparam logic [2:0] KIND_END  = 3'd3;
    localparam logic [2:0] KIND_ERR  = 3'd4;

    // Parameter defaults
    localparam int DEF_SECTOR_LIMIT  = 256;
    localparam int DEF_MAX_SIZE_CODE = 6;

    // One result beat
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  value;
        logic [7:0]  sector_id;
        logic [7:0]  cylinder_id;
        logic [7:0]  head_id;
        logic [7:0]  sector_index;
        logic [13:0] sector_bytes;
        logic [3:0]  sector_type;
        logic [2:0]  track_mode;
        logic        last_in_sector;
        logic        truncated;
    } res_t;

endpackage

// ===== hw/rtl/dtrd_map_ram.sv =====
// Map store: one write port, one read port, registered read data.
// Same-address write and read in one cycle returns the written byte.
// Depends on nothing.
module dtrd_map_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] map_mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            map_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= map_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/dtrd_parser.sv =====
// Track record parser: header/map sequencer, map stores, result formation.
// Uses dtrd_pkg and dtrd_map_ram.
module dtrd_parser
    import dtrd_pkg::*;
#(
    parameter int SECTOR_LIMIT  = DEF_SECTOR_LIMIT,
    parameter int MAX_SIZE_CODE = DEF_MAX_SIZE_CODE
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_accept,
    input  logic [7:0] stream_byte,
    input  logic       image_last,
    output logic       res_valid,
    output res_t       res
);

    localparam int IDX_W = (SECTOR_LIMIT > 1) ? $clog2(SECTOR_LIMIT) : 1;

    localparam logic [3:0] PH_MODE = 4'd0;
    localparam logic [3:0] PH_CYL  = 4'd1;
    localparam logic [3:0] PH_HEAD = 4'd2;
    localparam logic [3:0] PH_NSEC = 4'd3;
    localparam logic [3:0] PH_SIZE = 4'd4;
    localparam logic [3:0] PH_SMAP = 4'd5;
    localparam logic [3:0] PH_CMAP = 4'd6;
    localparam logic [3:0] PH_HMAP = 4'd7;
    localparam logic [3:0] PH_TYPE = 4'd8;
    localparam logic [3:0] PH_DATA = 4'd9;
    localparam logic [3:0] PH_FILL = 4'd10;

    localparam logic [7:0] MODE_MAX = 8'd5;
    localparam logic [7:0] TYPE_MAX = 8'd8;
    localparam int CMAP_BIT = 7;
    localparam int HMAP_BIT = 6;

    logic [3:0]  phase_reg, phase_next;
    logic        stopped_reg, stopped_next;
    logic [2:0]  mode_reg, mode_next;
    logic [7:0]  cyl_reg, cyl_next;
    logic [7:0]  flags_reg, flags_next;
    logic [7:0]  total_reg, total_next;
    logic [2:0]  size_reg, size_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [13:0] bc_reg, bc_next;
    logic [3:0]  type_reg, type_next;

    logic        we_num, we_cyl, we_head;
    logic [7:0]  rd_num, rd_cyl, rd_head;
    logic [IDX_W-1:0] waddr, raddr;

    logic        err, have;
    res_t        base, r;
    logic [8:0]  map_inc;
    logic [7:0]  ns_cnt;
    logic [13:0] bc_inc;
    logic [13:0] bytes_now;

    assign waddr = cnt_reg[IDX_W-1:0];
    // Read ahead at the counter value the next cycle will see.
    assign raddr = cnt_next[IDX_W-1:0];

    dtrd_map_ram #(.DEPTH(SECTOR_LIMIT), .AW(IDX_W)) u_num_ram (
        .clk(clk), .we(we_num), .waddr(waddr), .wdata(stream_byte),
        .raddr(raddr), .rdata(rd_num)
    );

    dtrd_map_ram #(.DEPTH(SECTOR_LIMIT), .AW(IDX_W)) u_cyl_ram (
        .clk(clk), .we(we_cyl), .waddr(waddr), .wdata(stream_byte),
        .raddr(raddr), .rdata(rd_cyl)
    );

    dtrd_map_ram #(.DEPTH(SECTOR_LIMIT), .AW(IDX_W)) u_head_ram (
        .clk(clk), .we(we_head), .waddr(waddr), .wdata(stream_byte),
        .raddr(raddr), .rdata(rd_head)
    );

    assign bytes_now = 14'd128 << size_reg;
    assign map_inc   = {1'b0, cnt_reg} + 9'd1;
    assign ns_cnt    = cnt_reg + 8'd1;
    assign bc_inc    = bc_reg + 14'd1;

    always_comb
    begin
        base                = '0;
        base.sector_id      = rd_num;
        base.cylinder_id    = flags_reg[CMAP_BIT] ? rd_cyl : cyl_reg;
        base.head_id        = flags_reg[HMAP_BIT] ? rd_head : {2'b00, flags_reg[5:0]};
        base.sector_index   = cnt_reg;
        base.sector_bytes   = bytes_now;
        base.sector_type    = type_reg;
        base.track_mode     = mode_reg;
    end

    always_comb
    begin
        phase_next   = phase_reg;
        stopped_next = stopped_reg;
        mode_next    = mode_reg;
        cyl_next     = cyl_reg;
        flags_next   = flags_reg;
        total_next   = total_reg;
        size_next    = size_reg;
        cnt_next     = cnt_reg;
        bc_next      = bc_reg;
        type_next    = type_reg;
        we_num       = 1'b0;
        we_cyl       = 1'b0;
        we_head      = 1'b0;
        err          = 1'b0;
        have         = 1'b0;
        r            = '0;
        res_valid    = 1'b0;
        res          = '0;

        if (in_accept && !stopped_reg)
        begin
            case (phase_reg)
                PH_MODE:
                begin
                    if (stream_byte > MODE_MAX)
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        mode_next  = stream_byte[2:0];
                        phase_next = PH_CYL;
                    end
                end
                PH_CYL:
                begin
                    cyl_next   = stream_byte;
                    phase_next = PH_HEAD;
                end
                PH_HEAD:
                begin
                    flags_next = stream_byte;
                    phase_next = PH_NSEC;
                end
                PH_NSEC:
                begin
                    if (stream_byte == 8'd0)
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        if ({1'b0, stream_byte} > 9'(SECTOR_LIMIT))
                        begin
                            total_next = 8'(SECTOR_LIMIT);
                        end
                        else
                        begin
                            total_next = stream_byte;
                        end
                        phase_next = PH_SIZE;
                    end
                end
                PH_SIZE:
                begin
                    if (stream_byte > 8'(MAX_SIZE_CODE))
                    begin
                        size_next = 3'(MAX_SIZE_CODE);
                    end
                    else
                    begin
                        size_next = stream_byte[2:0];
                    end
                    cnt_next   = 8'd0;
                    phase_next = PH_SMAP;
                end
                PH_SMAP, PH_CMAP, PH_HMAP:
                begin
                    we_num  = (phase_reg == PH_SMAP);
                    we_cyl  = (phase_reg == PH_CMAP);
                    we_head = (phase_reg == PH_HMAP);
                    if (map_inc >= {1'b0, total_reg})
                    begin
                        cnt_next = 8'd0;
                        if (phase_reg == PH_SMAP && flags_reg[CMAP_BIT])
                        begin
                            phase_next = PH_CMAP;
                        end
                        else if (phase_reg != PH_HMAP && flags_reg[HMAP_BIT])
                        begin
                            phase_next = PH_HMAP;
                        end
                        else
                        begin
                            phase_next = PH_TYPE;
                        end
                    end
                    else
                    begin
                        cnt_next = map_inc[7:0];
                    end
                end
                PH_TYPE:
                begin
                    if (stream_byte > TYPE_MAX)
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        type_next     = stream_byte[3:0];
                        r             = base;
                        r.kind        = KIND_DESC;
                        r.sector_type = stream_byte[3:0];
                        have          = 1'b1;
                        if (stream_byte == 8'd0)
                        begin
                            cnt_next   = ns_cnt;
                            phase_next = (ns_cnt >= total_reg) ? PH_MODE : PH_TYPE;
                        end
                        else if (stream_byte[0])
                        begin
                            bc_next    = 14'd0;
                            phase_next = PH_DATA;
                        end
                        else
                        begin
                            phase_next = PH_FILL;
                        end
                    end
                end
                PH_DATA:
                begin
                    bc_next = bc_inc;
                    r       = base;
                    r.kind  = KIND_DATA;
                    r.value = stream_byte;
                    have    = 1'b1;
                    if (bc_inc >= bytes_now)
                    begin
                        r.last_in_sector = 1'b1;
                        cnt_next         = ns_cnt;
                        phase_next       = (ns_cnt >= total_reg) ? PH_MODE : PH_TYPE;
                    end
                end
                PH_FILL:
                begin
                    r                = base;
                    r.kind           = KIND_FILL;
                    r.value          = stream_byte;
                    r.last_in_sector = 1'b1;
                    have             = 1'b1;
                    cnt_next         = ns_cnt;
                    phase_next       = (ns_cnt >= total_reg) ? PH_MODE : PH_TYPE;
                end
                default:
                begin
                    phase_next = PH_MODE;
                end
            endcase

            if (err)
            begin
                stopped_next = 1'b1;
                res_valid    = 1'b1;
                res          = '0;
                res.kind     = KIND_ERR;
            end
            else if (image_last)
            begin
                res_valid      = 1'b1;
                res            = have ? r : '0;
                res.kind       = KIND_END;
                res.track_mode = mode_next;
                res.truncated  = (phase_next != PH_MODE);
                phase_next     = PH_MODE;
            end
            else
            begin
                res_valid = have;
                res       = r;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_MODE;
            stopped_reg <= 1'b0;
            mode_reg    <= '0;
            cyl_reg     <= '0;
            flags_reg   <= '0;
            total_reg   <= '0;
            size_reg    <= '0;
            cnt_reg     <= '0;
            bc_reg      <= '0;
            type_reg    <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            stopped_reg <= stopped_next;
            mode_reg    <= mode_next;
            cyl_reg     <= cyl_next;
            flags_reg   <= flags_next;
            total_reg   <= total_next;
            size_reg    <= size_next;
            cnt_reg     <= cnt_next;
            bc_reg      <= bc_next;
            type_reg    <= type_next;
        end
    end

endmodule

// ===== hw/rtl/dtrd_out_buf.sv =====
// Result buffer: output register plus one skid entry.
// Upstream stall is the registered skid-full flag. Uses dtrd_pkg.
module dtrd_out_buf
    import dtrd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_data,
    output logic full,
    output logic out_valid,
    input  logic out_stall,
    output res_t out_data
);

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t out_data_reg, out_data_next;
    res_t skid_data_reg, skid_data_next;
    logic take;

    assign take = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hw/rtl/disk_image_track_record_decoder.sv =====
// Top level of the disk image track record decoder.
// Depends on dtrd_pkg, dtrd_parser (with dtrd_map_ram) and dtrd_out_buf.
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------
//  in      | in_valid / in_stall | stream_byte, image_last
//  out     | out_valid/out_stall | kind, value, sector_id, cylinder_id,
//          |                     | head_id, sector_index, sector_bytes,
//          |                     | sector_type, track_mode, last_in_sector,
//          |                     | truncated
//
// One input beat per cycle while in_stall is low; a result (if any) is
// registered in the output register or the skid entry. Map stores are read
// ahead at the next sector index, so the registered read costs no throughput.
// Reset is asynchronous; the map stores hold no reset value and need none,
// since every entry is written by the track header before it is read.
// in_stall rises only once the skid entry behind the output register is
// occupied, i.e. after two undelivered results.
module disk_image_track_record_decoder
    import dtrd_pkg::*;
#(
    parameter int SECTOR_LIMIT  = DEF_SECTOR_LIMIT,
    parameter int MAX_SIZE_CODE = DEF_MAX_SIZE_CODE
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  stream_byte,
    input  logic        image_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [7:0]  value,
    output logic [7:0]  sector_id,
    output logic [7:0]  cylinder_id,
    output logic [7:0]  head_id,
    output logic [7:0]  sector_index,
    output logic [13:0] sector_bytes,
    output logic [3:0]  sector_type,
    output logic [2:0]  track_mode,
    output logic        last_in_sector,
    output logic        truncated
);

    logic in_accept;
    logic res_valid;
    res_t res;
    res_t out_data;
    logic buf_full;

    // Beat taken whenever the skid entry is free.
    assign in_stall  = buf_full;
    assign in_accept = in_valid && !buf_full;

    // Header/map sequencer and map stores; forms at most one result per beat.
    dtrd_parser #(
        .SECTOR_LIMIT(SECTOR_LIMIT),
        .MAX_SIZE_CODE(MAX_SIZE_CODE)
    ) u_parser (
        .clk(clk),
        .rst_n(rst_n),
        .in_accept(in_accept),
        .stream_byte(stream_byte),
        .image_last(image_last),
        .res_valid(res_valid),
        .res(res)
    );

    // Decouples the downstream stall from the input side.
    dtrd_out_buf u_out_buf (
        .clk(clk),
        .rst_n(rst_n),
        .push(res_valid),
        .push_data(res),
        .full(buf_full),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    assign kind           = out_data.kind;
    assign value          = out_data.value;
    assign sector_id      = out_data.sector_id;
    assign cylinder_id    = out_data.cylinder_id;
    assign head_id        = out_data.head_id;
    assign sector_index   = out_data.sector_index;
    assign sector_bytes   = out_data.sector_bytes;
    assign sector_type    = out_data.sector_type;
    assign track_mode     = out_data.track_mode;
    assign last_in_sector = out_data.last_in_sector;
    assign truncated      = out_data.truncated;

endmodule

// ===== hw/rtl/dtrd_checker.sv =====
// Port-level checks for disk_image_track_record_decoder, bound to the top.
// Uses dtrd_pkg.
module dtrd_checker
    import dtrd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  stream_byte,
    input logic        image_last,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  kind,
    input logic [7:0]  value,
    input logic [7:0]  sector_id,
    input logic [7:0]  cylinder_id,
    input logic [7:0]  head_id,
    input logic [7:0]  sector_index,
    input logic [13:0] sector_bytes,
    input logic [3:0]  sector_type,
    input logic [2:0]  track_mode,
    input logic        last_in_sector,
    input logic        truncated
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(value))
        else $error("stalled result beat changed");

    // out_valid drops once an error beat is delivered
    a_err_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && kind == KIND_ERR |=> !out_valid)
        else $error("result after error beat");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ERR |->
            value == 8'd0 && sector_bytes == 14'd0 && track_mode == 3'd0)
        else $error("error beat carries data");

    a_fill_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_FILL |-> last_in_sector)
        else $error("fill beat without last_in_sector");

    a_trunc_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_END |-> !truncated)
        else $error("truncated outside image end beat");

endmodule

bind disk_image_track_record_decoder dtrd_checker u_dtrd_checker (.*);
